/* src/pcxd_pkg.sv */
// Shared types and constants for the run-length pixel decoder.
// No dependencies; every other file imports this package.
package pcxd_pkg;

    localparam int DIM_W       = 12;
    localparam int COUNT_W     = 24;
    localparam int RUN_W       = 6;
    localparam int PIX_W       = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DIM_W-1:0] LINE_WIDTH_RST = DIM_W'(640);
    localparam logic [DIM_W-1:0] LINE_TOTAL_RST = DIM_W'(800);
    localparam logic [COUNT_W-1:0] IMAGE_SIZE_RST = COUNT_W'(640 * 800);

    localparam logic [PIX_W-1:0] RUN_MARK     = 8'hc0;
    localparam logic [PIX_W-1:0] RUN_LEN_MASK = 8'h3f;

    typedef enum logic [2:0] {
        ST_PIXEL    = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_ZERO_RUN = 3'd2,
        ST_NO_VALUE = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_CROSSES  = 3'd5,
        ST_TOO_FEW  = 3'd6,
        ST_TRAILING = 3'd7
    } status_t;

    typedef enum logic [0:0] {
        REG_LINE_WIDTH = 1'b0,
        REG_LINE_TOTAL = 1'b1
    } reg_idx_t;

    // One unit of work for the back end: count pixels of one value, then an
    // optional status result.
    typedef struct packed {
        logic [RUN_W-1:0] count;
        logic [PIX_W-1:0] value;
        logic             has_status;
        status_t          status;
    } cmd_t;

endpackage

/* src/pcxd_ifs.sv */
// Channel interfaces: compressed byte input, decoded result output, config writes.
// Depends on pcxd_pkg.
interface pcxd_code_if;
    import pcxd_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] data_byte;
    logic             start_of_image;
    logic             last_byte;

    modport source (output valid, data_byte, start_of_image, last_byte, input ready);
    modport sink   (input valid, data_byte, start_of_image, last_byte, output ready);
endinterface

interface pcxd_pixel_if;
    import pcxd_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic [2:0]       status;
    logic             last_of_item;

    modport source (output valid, pixel_value, status, last_of_item, input ready);
    modport sink   (input valid, pixel_value, status, last_of_item, output ready);
endinterface

interface pcxd_cfg_if;
    import pcxd_pkg::*;
    logic             valid;
    logic             ready;
    logic [0:0]       index;
    logic [DIM_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/pcx_rle_pixel_decoder.sv */
// Run-length pixel decoder for 8-bit paletted image data. A literal byte gives
// one pixel beat; a run token gives none, its value byte one beat per pixel
// (1 to 63), plus a status beat when one follows. The front end takes a byte
// per cycle until the command queue (QUEUE_DEPTH entries, default 2) is full,
// so sustained throughput is one result beat per cycle while the output is
// not stalled, set by the back end's single output register. Input ready
// drops in the cycle after each config write while the image size product
// is recomputed. Errors halt decoding until a byte with start_of_image.
// Depends on pcxd_pkg, pcxd_ifs, pcxd_front, pcxd_queue, pcxd_back.
module pcx_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = pcxd_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    pcxd_code_if.sink    code,
    pcxd_pixel_if.source pixel,
    pcxd_cfg_if.sink     cfg
);
    import pcxd_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic q_valid;
    cmd_t q_head;
    logic pop;

    pcxd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .code     (code),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    pcxd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    pcxd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .pop     (pop),
        .pixel   (pixel)
    );

endmodule

/* src/pcxd_front.sv */
// Front end: config registers, byte classification, image position tracking.
// Pushes one command per byte that causes results. Depends on pcxd_pkg, pcxd_ifs.
module pcxd_front (
    input  logic              clk,
    input  logic              rst_n,
    pcxd_code_if.sink         code,
    pcxd_cfg_if.sink          cfg,
    input  logic              q_full,
    output logic              push,
    output pcxd_pkg::cmd_t    push_cmd
);
    import pcxd_pkg::*;

    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   total_reg, total_next;
    logic [COUNT_W-1:0] size_reg;
    logic               cfg_pend_reg;

    logic               aw_reg, aw_next;
    logic [RUN_W-1:0]   pend_reg, pend_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [COUNT_W-1:0] pe_reg, pe_next;
    logic               halt_reg, halt_next;

    logic               aw_e, halt_e;
    logic [RUN_W-1:0]   pend_e;
    logic [DIM_W-1:0]   col_e;
    logic [COUNT_W-1:0] pe_e;
    logic [RUN_W-1:0]   cnt;
    logic [COUNT_W:0]   pe_sum;
    logic [DIM_W:0]     col_sum;
    logic [RUN_W-1:0]   tok_len;
    logic               is_token;
    logic               accept;
    logic               cfg_accept;

    assign cfg.ready  = 1'b1;
    assign cfg_accept = cfg.valid;
    // Hold input in the cycle after a config write so the image size catches up.
    assign code.ready = !q_full && !cfg_pend_reg;
    assign accept     = code.valid && code.ready;

    always_comb
    begin
        width_next = width_reg;
        total_next = total_reg;
        if (cfg_accept)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_LINE_WIDTH: width_next = cfg.data;
                REG_LINE_TOTAL: total_next = cfg.data;
            endcase
        end
    end

    // Effective state after an optional start of image.
    assign aw_e   = code.start_of_image ? 1'b0 : aw_reg;
    assign pend_e = code.start_of_image ? '0 : pend_reg;
    assign col_e  = code.start_of_image ? '0 : col_reg;
    assign pe_e   = code.start_of_image ? '0 : pe_reg;
    assign halt_e = code.start_of_image ? 1'b0 : halt_reg;

    assign tok_len  = RUN_W'(code.data_byte & RUN_LEN_MASK);
    assign is_token = (code.data_byte & RUN_MARK) == RUN_MARK;
    assign cnt      = aw_e ? pend_e : RUN_W'(1);
    assign pe_sum   = {1'b0, pe_e} + (COUNT_W+1)'(cnt);
    assign col_sum  = {1'b0, col_e} + (DIM_W+1)'(cnt);

    always_comb
    begin
        logic run_go;
        logic fail_go;
        status_t fail_st;

        run_go  = 1'b0;
        fail_go = 1'b0;
        fail_st = ST_TRAILING;

        aw_next   = aw_e;
        pend_next = pend_e;
        col_next  = col_e;
        pe_next   = pe_e;
        halt_next = halt_e;

        push                = 1'b0;
        push_cmd.count      = cnt;
        push_cmd.value      = code.data_byte;
        push_cmd.has_status = 1'b0;
        push_cmd.status     = ST_PIXEL;

        if (!halt_e)
        begin
            if (aw_e)
            begin
                aw_next   = 1'b0;
                pend_next = '0;
                run_go    = 1'b1;
            end
            else if (pe_e >= size_reg)
            begin
                fail_go = 1'b1;
                fail_st = ST_TRAILING;
            end
            else if (is_token)
            begin
                if (tok_len == '0)
                begin
                    fail_go = 1'b1;
                    fail_st = ST_ZERO_RUN;
                end
                else if (code.last_byte)
                begin
                    fail_go = 1'b1;
                    fail_st = ST_NO_VALUE;
                end
                else
                begin
                    aw_next   = 1'b1;
                    pend_next = tok_len;
                end
            end
            else
            begin
                run_go = 1'b1;
            end
        end

        if (run_go)
        begin
            if (pe_sum > {1'b0, size_reg})
            begin
                fail_go = 1'b1;
                fail_st = ST_OVERFLOW;
            end
            else if (col_sum > {1'b0, width_reg})
            begin
                fail_go = 1'b1;
                fail_st = ST_CROSSES;
            end
            else
            begin
                push     = 1'b1;
                pe_next  = pe_sum[COUNT_W-1:0];
                col_next = (col_sum >= {1'b0, width_reg}) ? '0 : col_sum[DIM_W-1:0];
                if (code.last_byte)
                begin
                    push_cmd.has_status = 1'b1;
                    if (pe_sum[COUNT_W-1:0] == size_reg)
                    begin
                        push_cmd.status = ST_COMPLETE;
                    end
                    else
                    begin
                        push_cmd.status = ST_TOO_FEW;
                        halt_next       = 1'b1;
                    end
                end
            end
        end

        if (fail_go)
        begin
            push                = 1'b1;
            push_cmd.count      = '0;
            push_cmd.value      = '0;
            push_cmd.has_status = 1'b1;
            push_cmd.status     = fail_st;
            halt_next           = 1'b1;
            aw_next             = 1'b0;
            pend_next           = '0;
        end

        if (!accept)
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= LINE_WIDTH_RST;
            total_reg    <= LINE_TOTAL_RST;
            size_reg     <= IMAGE_SIZE_RST;
            cfg_pend_reg <= 1'b0;
            aw_reg       <= 1'b0;
            pend_reg     <= '0;
            col_reg      <= '0;
            pe_reg       <= '0;
            halt_reg     <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            total_reg    <= total_next;
            size_reg     <= {{(COUNT_W-DIM_W){1'b0}}, width_reg}
                          * {{(COUNT_W-DIM_W){1'b0}}, total_reg};
            cfg_pend_reg <= cfg_accept;
            if (accept)
            begin
                aw_reg   <= aw_next;
                pend_reg <= pend_next;
                col_reg  <= col_next;
                pe_reg   <= pe_next;
                halt_reg <= halt_next;
            end
        end
    end

endmodule

/* src/pcxd_queue.sv */
// Small command FIFO between the front and back ends.
// Depends on pcxd_pkg.
module pcxd_queue #(
    parameter int DEPTH = pcxd_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pcxd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output pcxd_pkg::cmd_t head
);
    import pcxd_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            slot_reg [DEPTH];
    logic [IW-1:0]   wr_reg, wr_next;
    logic [IW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign full    = fill_reg == CW'(DEPTH);
    assign valid   = fill_reg != '0;
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == IW'(DEPTH - 1)) ? '0 : wr_reg + IW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == IW'(DEPTH - 1)) ? '0 : rd_reg + IW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

/* src/pcxd_back.sv */
// Back end: expands commands into pixel beats and an optional trailing status
// beat, through a registered output. Depends on pcxd_pkg, pcxd_ifs.
module pcxd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  pcxd_pkg::cmd_t q_head,
    output logic           pop,
    pcxd_pixel_if.source   pixel
);
    import pcxd_pkg::*;

    logic [RUN_W-1:0] sent_reg, sent_next;
    logic             out_valid_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [2:0]       st_reg;
    logic             last_reg;

    logic             load;
    logic             in_pixels;
    logic             final_beat;
    logic [PIX_W-1:0] pix_next;
    logic [2:0]       st_next;
    logic             last_next;

    assign load      = q_valid && (!out_valid_reg || pixel.ready);
    assign in_pixels = sent_reg < q_head.count;

    always_comb
    begin
        if (in_pixels)
        begin
            pix_next   = q_head.value;
            st_next    = ST_PIXEL;
            final_beat = (sent_reg == q_head.count - RUN_W'(1)) && !q_head.has_status;
            last_next  = final_beat;
        end
        else
        begin
            pix_next   = '0;
            st_next    = q_head.status;
            final_beat = 1'b1;
            last_next  = 1'b1;
        end
        pop = load && final_beat;
        if (pop)
        begin
            sent_next = '0;
        end
        else if (load)
        begin
            sent_next = sent_reg + RUN_W'(1);
        end
        else
        begin
            sent_next = sent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg <= sent_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg  <= pix_next;
            st_reg   <= st_next;
            last_reg <= last_next;
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.pixel_value  = pix_reg;
    assign pixel.status       = st_reg;
    assign pixel.last_of_item = last_reg;

endmodule

/* src/pcxd_checker.sv */
// Port-level checks for the decoder, bound onto the top level.
// Depends on pcxd_pkg and pcx_rle_pixel_decoder.
module pcxd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       code_ready,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_pixel,
    input logic [2:0] out_status,
    input logic       out_last
);
    import pcxd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel)
            && $stable(out_status) && $stable(out_last))
        else $error("result changed while stalled");

    a_status_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_PIXEL |-> out_pixel == '0)
        else $error("status beat carries a pixel value");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_PIXEL |-> out_last)
        else $error("status beat not marked last");

    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !code_ready)
        else $error("byte taken right after config write");

endmodule

bind pcx_rle_pixel_decoder pcxd_checker u_pcxd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .code_ready (code.ready),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .out_valid  (pixel.valid),
    .out_ready  (pixel.ready),
    .out_pixel  (pixel.pixel_value),
    .out_status (pixel.status),
    .out_last   (pixel.last_of_item)
);

/* verif/tb_pcx_rle_pixel_decoder.sv */
// Self-checking testbench for the run-length pixel decoder: random and directed
// byte streams, register writes and random idling on both channels.
// Depends on pcxd_pkg, the channel interfaces in pcxd_ifs and the decoder RTL.
module tb_pcx_rle_pixel_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import pcxd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 340;
    localparam int HOLD_PHASE     = 2;
    localparam int MAX_IMAGE_BYTES = 48;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        status_t          status;
        logic             last;
    } pixel_beat_t;

    typedef struct {
        logic [PIX_W-1:0] data;
        logic             sof;
        logic             last;
    } code_beat_t;

    // Tracks the decoder state per accepted byte and holds the pixel beats owed.
    class rle_pixel_scoreboard;
        logic [DIM_W-1:0]   width_reg;
        logic [DIM_W-1:0]   lines_reg;
        logic               awaiting_value;
        logic [RUN_W-1:0]   run_len;
        logic [DIM_W-1:0]   column;
        logic [COUNT_W-1:0] pixels_out;
        logic               halted;
        pixel_beat_t        expected_beats[$];
        int                 mismatches;
        int                 seen_bytes;

        function new();
            width_reg  = LINE_WIDTH_RST;
            lines_reg  = LINE_TOTAL_RST;
            mismatches = 0;
            seen_bytes = 0;
            clear_image();
        endfunction

        function void clear_image();
            awaiting_value = 1'b0;
            run_len        = '0;
            column         = '0;
            pixels_out     = '0;
            halted         = 1'b0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [DIM_W-1:0] val);
            if (idx == REG_LINE_WIDTH)
                width_reg = val;
            else
                lines_reg = val;
        endfunction

        function int image_pixels();
            return (int'(width_reg) * int'(lines_reg)) & 24'hffffff;
        endfunction

        function void owe_beat(logic [PIX_W-1:0] pix, status_t st, logic last);
            pixel_beat_t b;
            b.pixel  = pix;
            b.status = st;
            b.last   = last;
            expected_beats.insert(expected_beats.size(), b);
        endfunction

        function void halt_with(status_t st);
            halted         = 1'b1;
            awaiting_value = 1'b0;
            run_len        = '0;
            owe_beat('0, st, 1'b1);
        endfunction

        function void emit_run(int count, logic [PIX_W-1:0] value, logic last_in);
            int total;
            int remaining;
            int room;
            int col;
            int i;
            total     = image_pixels();
            remaining = (int'(pixels_out) >= total) ? 0 : total - int'(pixels_out);
            room      = (column >= width_reg) ? 0 : int'(width_reg) - int'(column);
            if (count > remaining) begin
                halt_with(ST_OVERFLOW);
                return;
            end
            if (count > room) begin
                halt_with(ST_CROSSES);
                return;
            end
            for (i = 0; i < count; i++)
                owe_beat(value, ST_PIXEL, !last_in && i == count - 1);
            pixels_out = COUNT_W'(int'(pixels_out) + count);
            col        = int'(column) + count;
            column     = (col >= int'(width_reg)) ? '0 : DIM_W'(col);
            if (last_in) begin
                if (int'(pixels_out) == total)
                    owe_beat('0, ST_COMPLETE, 1'b1);
                else
                begin
                    halted = 1'b1;
                    owe_beat('0, ST_TOO_FEW, 1'b1);
                end
            end
        endfunction

        function void decode_byte(logic [PIX_W-1:0] data, logic sof, logic last_in);
            int count;
            seen_bytes++;
            if (sof)
                clear_image();
            if (halted)
                return;
            if (awaiting_value) begin
                count          = int'(run_len);
                awaiting_value = 1'b0;
                run_len        = '0;
                emit_run(count, data, last_in);
                return;
            end
            if (int'(pixels_out) >= image_pixels()) begin
                halt_with(ST_TRAILING);
                return;
            end
            if ((data & RUN_MARK) == RUN_MARK) begin
                count = int'(data & RUN_LEN_MASK);
                if (count == 0)
                    halt_with(ST_ZERO_RUN);
                else if (last_in)
                    halt_with(ST_NO_VALUE);
                else
                begin
                    awaiting_value = 1'b1;
                    run_len        = RUN_W'(count);
                end
                return;
            end
            emit_run(1, data, last_in);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch: %s", $realtime, msg);
        endfunction

        function void check_pixel_beat(logic [PIX_W-1:0] pix, logic [2:0] st, logic last);
            pixel_beat_t want;
            if (expected_beats.size() == 0) begin
                note_mismatch($sformatf("unexpected beat pixel %0h status %0d last %0b",
                                        pix, st, last));
                return;
            end
            want = expected_beats.pop_front();
            if (pix !== want.pixel || st !== want.status || last !== want.last)
                note_mismatch($sformatf(
                    "got pixel %0h status %0d last %0b, want pixel %0h status %s last %0b",
                    pix, st, last, want.pixel, want.status.name(), want.last));
        endfunction

        function int error_count();
            return mismatches + expected_beats.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pcxd_code_if  code_if();
    pcxd_pixel_if pixel_if();
    pcxd_cfg_if   cfg_if();

    pcx_rle_pixel_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .code  (code_if),
        .pixel (pixel_if),
        .cfg   (cfg_if)
    );

    rle_pixel_scoreboard decoder_sb = new();
    code_beat_t          image_q[$];
    int                  burst_left  = 0;
    int                  idle_cycles = 0;
    bit                  hold_req    = 1'b0;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Offer one byte; the sender idles between bursts of random length.
    task automatic send_code(code_beat_t beat);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                code_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        code_if.valid          <= 1'b1;
        code_if.data_byte      <= beat.data;
        code_if.start_of_image <= beat.sof;
        code_if.last_byte      <= beat.last;
        @(posedge clk);
        while (!code_if.ready)
            @(posedge clk);
        decoder_sb.decode_byte(beat.data, beat.sof, beat.last);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_byte(int data, bit sof, bit last);
        code_beat_t beat;
        beat = '{data: PIX_W'(data), sof: sof, last: last};
        send_code(beat);
    endtask

    task automatic send_image();
        foreach (image_q[i])
            send_code(image_q[i]);
    endtask

    // Drop valid, wait for every owed beat, then let the pipeline settle.
    task automatic wait_idle();
        code_if.valid <= 1'b0;
        burst_left = 0;
        while (decoder_sb.expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(reg_idx_t idx, int val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= DIM_W'(val);
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        decoder_sb.write_reg(idx, DIM_W'(val));
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void add_beat(int data, bit sof, bit last);
        code_beat_t beat;
        beat = '{data: PIX_W'(data), sof: sof, last: last};
        image_q.insert(image_q.size(), beat);
    endfunction

    // Well-formed stream for a w x lines image, cut short at max_bytes.
    function automatic void build_image(int w, int lines, int max_bytes);
        int total;
        int done;
        int cap;
        int n;
        image_q.delete();
        total = w * lines;
        done  = 0;
        while (done < total && image_q.size() < max_bytes) begin
            cap = w - (done % w);
            if (cap > 63)
                cap = 63;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cap)
                                            : $urandom_range(1, (cap + 3) / 4);
            if (n == 1 && $urandom_range(0, 1) == 1)
                add_beat($urandom_range(0, 8'hbf), 1'b0, 1'b0);
            else
            begin
                add_beat(int'(RUN_MARK) | n, 1'b0, 1'b0);
                add_beat($urandom_range(0, 255), 1'b0, 1'b0);
            end
            done += n;
        end
        image_q[0].sof = 1'b1;
        if (done == total)
            image_q[image_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void break_image();
        int pos;
        int k;
        code_beat_t zero_run;
        pos      = $urandom_range(0, image_q.size() - 1);
        zero_run = '{data: RUN_MARK, sof: 1'b0, last: 1'b0};
        case ($urandom_range(0, 4))
            0: image_q[pos].data = PIX_W'($urandom_range(0, 255));
            1: image_q[pos].last = 1'b1;
            2:
            begin
                if (image_q.size() > 1)
                    image_q.insert($urandom_range(1, image_q.size() - 1), zero_run);
                else
                    image_q.insert(image_q.size(), zero_run);
            end
            3:
            begin
                for (k = $urandom_range(1, 3); k > 0; k--)
                    add_beat($urandom_range(0, 255), 1'b0, 1'b0);
            end
            default:
            begin
                // image without the end mark, then one more byte
                image_q[image_q.size() - 1].last = 1'b0;
                add_beat($urandom_range(0, 255), 1'b0, 1'($urandom_range(0, 1)));
            end
        endcase
    endfunction

    function automatic void build_noise();
        int k;
        image_q.delete();
        for (k = $urandom_range(1, 8); k > 0; k--)
            add_beat($urandom_range(0, 255), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 3) == 0);
    endfunction

    // Result side: stall pattern of its own, plus one long hold on request.
    initial begin : pixel_sink
        int span;
        int mode;
        int k;
        pixel_if.ready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_req) begin
                pixel_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(1, 40);
                for (k = 0; k < span && !hold_req; k++) begin
                    case (mode)
                        0:       pixel_if.ready <= 1'b1;
                        1:       pixel_if.ready <= 1'($urandom_range(0, 1));
                        2:       pixel_if.ready <= ($urandom_range(0, 3) != 0);
                        default: pixel_if.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1)
            decoder_sb.check_pixel_beat(pixel_if.pixel_value, pixel_if.status,
                                        pixel_if.last_of_item);
    end

    always @(posedge clk) begin
        if ((code_if.valid === 1'b1 && code_if.ready === 1'b1)
            || (pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1)
            || (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int w;
        int lines;
        int kind;
        int n_images;
        code_if.valid          = 1'b0;
        code_if.data_byte      = '0;
        code_if.start_of_image = 1'b0;
        code_if.last_byte      = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.index           = REG_LINE_WIDTH;
        cfg_if.data            = '0;
        rst_n                  = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry: literal zero, longest run of 0xff, literal 0xbf, then a zero-length run
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'hbf, 1'b0, 1'b0);
        send_byte(8'hc0, 1'b0, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);
        wait_idle();

        // 4 x 2 image: completion, trailing data, crossing, missing value, zero run, too few
        write_cfg(REG_LINE_WIDTH, 4);
        write_cfg(REG_LINE_TOTAL, 2);
        send_byte(8'hc4, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h7f, 1'b0, 1'b0);
        send_byte(8'hc3, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hc5, 1'b1, 1'b0);
        send_byte(8'h33, 1'b0, 1'b0);
        send_byte(8'hc2, 1'b1, 1'b1);
        send_byte(8'hc0, 1'b1, 1'b1);
        send_byte(8'h40, 1'b1, 1'b1);
        send_byte(8'hc1, 1'b1, 1'b0);
        send_byte(8'hc2, 1'b1, 1'b0);
        send_byte(8'h20, 1'b0, 1'b0);
        wait_idle();

        // Shrink the width mid-image so the column is already past the line end
        write_cfg(REG_LINE_WIDTH, 1);
        write_cfg(REG_LINE_TOTAL, 4095);
        send_byte(8'h10, 1'b0, 1'b0);
        wait_idle();

        write_cfg(REG_LINE_WIDTH, 8);
        write_cfg(REG_LINE_TOTAL, 1);
        send_byte(8'hc6, 1'b1, 1'b0);
        send_byte(8'h9a, 1'b0, 1'b0);
        send_byte(8'hc3, 1'b0, 1'b0);
        send_byte(8'hee, 1'b0, 1'b0);

        phase = 0;
        while (decoder_sb.seen_bytes < DIRECTED_ITEMS + RANDOM_ITEMS || phase <= HOLD_PHASE)
        begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       begin w = 1;                      lines = $urandom_range(1, 8); end
                1:       begin w = $urandom_range(1, 16);  lines = 1;                    end
                2:       begin w = 4095;                   lines = 1;                    end
                default: begin w = $urandom_range(1, 16);  lines = $urandom_range(1, 5); end
            endcase
            if (phase == 0) begin
                w     = 4095;
                lines = 4095;
            end
            if (phase == HOLD_PHASE) begin
                w     = 48;
                lines = 4;
            end
            if ($urandom_range(0, 1) == 1) begin
                write_cfg(REG_LINE_WIDTH, w);
                write_cfg(REG_LINE_TOTAL, lines);
            end
            else
            begin
                write_cfg(REG_LINE_TOTAL, lines);
                write_cfg(REG_LINE_WIDTH, w);
            end
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            n_images = $urandom_range(1, 4);
            repeat (n_images) begin
                kind = $urandom_range(0, 9);
                if (kind == 9)
                    build_noise();
                else
                begin
                    build_image(w, lines, MAX_IMAGE_BYTES);
                    if (kind >= 6)
                        break_image();
                    else if (kind == 5)
                        image_q[0].sof = 1'b0;  // continue whatever image is open
                end
                send_image();
            end
            phase++;
        end

        wait_idle();
        if (decoder_sb.error_count() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/pcxd_pkg.sv
src/pcxd_ifs.sv
src/pcxd_front.sv
src/pcxd_queue.sv
src/pcxd_back.sv
src/pcx_rle_pixel_decoder.sv
src/pcxd_checker.sv
verif/tb_pcx_rle_pixel_decoder.sv
